// ===== rtl/core/udfte_pkg.sv =====
// Types, constants and a lookup function for the timestamp to epoch converter.
package udfte_pkg;

   localparam int unsigned OP_A_W = 25;
   localparam int unsigned OP_B_W = 18;
   localparam int unsigned ACC_W  = 40;
   localparam int unsigned PROD_W = OP_A_W + OP_B_W;
   localparam int unsigned Q100_W = 8;

   localparam logic [13:0] EPOCH_YEAR          = 14'd1970;
   localparam logic [13:0] CENTURY_LAST        = 14'd99;
   localparam int signed   LEAPS_BEFORE_EPOCH  = 477;
   localparam int signed   RECIP_100           = 10486;
   localparam int unsigned RECIP_SHIFT         = 20;
   localparam int signed   DAYS_PER_YEAR       = 365;
   localparam int signed   SECS_PER_DAY        = 86400;
   localparam int signed   SECS_PER_HOUR       = 3600;
   localparam int signed   SECS_PER_MIN        = 60;
   localparam logic [3:0]  LAST_MONTH          = 4'd12;
   localparam logic [3:0]  FEBRUARY            = 4'd2;
   localparam logic signed [11:0] ZONE_UNSPEC  = -12'sd2047;
   localparam int unsigned ZONE_APPLY_BIT      = 12;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [15:0] type_and_zone;
   } req_type;

   typedef struct packed {
      logic signed [38:0] epoch_seconds;
      logic               before_epoch;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RECIP,
      ST_YEARS,
      ST_LEAPS,
      ST_MONTHS,
      ST_DAYS,
      ST_HOURS,
      ST_MINUTES,
      ST_ZONE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                      en;
      logic                      keep;
      logic signed [OP_A_W-1:0]  op_a;
      logic signed [OP_B_W-1:0]  op_b;
      logic signed [OP_A_W-1:0]  addend;
   } mac_ctrl_type;

   // days before the first of month idx+1, common year
   function automatic logic [8:0] days_before_month(input logic [3:0] idx);
      logic [8:0] d;
      unique case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/core/udfte_mac.sv =====
// Shared multiply-accumulate unit: while en is high, acc <= (keep ? acc : 0) + a * b + addend.
module udfte_mac (
   input  logic                                   clock,
   input  udfte_pkg::mac_ctrl_type                ctrl,
   output logic signed [udfte_pkg::ACC_W-1:0]     acc
);
   import udfte_pkg::*;

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  addend_ext;

   assign prod       = ctrl.op_a * ctrl.op_b;
   assign base       = ctrl.keep ? acc_ff : '0;
   assign addend_ext = {{(ACC_W-OP_A_W){ctrl.addend[OP_A_W-1]}}, ctrl.addend};
   assign acc_in     = base + signed'(prod[ACC_W-1:0]) + addend_ext;

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/core/udf_timestamp_to_epoch_core.sv =====
// Top level of the recorded-timestamp to epoch-seconds converter.
// A request is taken when start is high and busy is low; busy then stays high until the
// result has been shown. For a timestamp from 1970 onward, the request makes its passes
// through the single shared multiply-accumulate unit, each in its own state (reciprocal
// divide by 100, year days, leap correction, month and day, days to seconds, hours, minutes
// and seconds, zone offset), and rsp_strobe is then raised in the done state. A year
// before 1970 gives its flagged zero result in the cycle right after the accepting edge. The
// result is valid for exactly the one rsp_strobe cycle and cannot be stalled; the receiver
// must take it then. The next request may start in the cycle after.
module udf_timestamp_to_epoch_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  udfte_pkg::req_type  req_data,
   output logic                rsp_strobe,
   output udfte_pkg::rsp_type  rsp_data
);
   import udfte_pkg::*;

   state_type             state_ff;
   state_type             state_in;
   req_type               req_ff;
   logic                  before_ff;
   logic [Q100_W-1:0]     q100_ff;
   logic                  leap_ff;
   logic                  leap_in;
   mac_ctrl_type          mac_ctrl;
   logic signed [ACC_W-1:0] acc;

   logic [13:0]           ym1;
   logic [13:0]           yoff;
   logic [13:0]           century_rem;
   logic [Q100_W-1:0]     q_year;
   logic                  century;
   logic [3:0]            month_clamp;
   logic [9:0]            month_days;
   logic [4:0]            day_off;
   logic signed [11:0]    zone;
   logic                  zone_apply;
   logic                  accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign ym1    = req_ff.year - 14'd1;
   assign yoff   = req_ff.year - EPOCH_YEAR;

   // ym1 mod 100 from the reciprocal quotient; year is a century when it is 99
   assign century_rem = ym1 - (({6'd0, q100_ff} << 6) + ({6'd0, q100_ff} << 5)
                             + ({6'd0, q100_ff} << 2));
   assign century     = (century_rem == CENTURY_LAST);
   assign q_year      = q100_ff + Q100_W'(1);
   assign leap_in     = (req_ff.year[1:0] == 2'd0) && (!century || (q_year[1:0] == 2'd0));

   assign month_clamp = (req_ff.month > LAST_MONTH) ? LAST_MONTH : req_ff.month;
   assign month_days  = (month_clamp == 4'd0) ? 10'd0 :
                        {1'b0, days_before_month(month_clamp - 4'd1)}
                        + {9'd0, (month_clamp > FEBRUARY) && leap_ff};
   assign day_off     = (req_ff.day == 5'd0) ? 5'd0 : req_ff.day - 5'd1;

   assign zone       = signed'(req_ff.type_and_zone[11:0]);
   assign zone_apply = req_ff.type_and_zone[ZONE_APPLY_BIT] && (zone != ZONE_UNSPEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_data.year < EPOCH_YEAR) ? ST_DONE : ST_RECIP;
            end
         end
         ST_RECIP:   state_in = ST_YEARS;
         ST_YEARS:   state_in = ST_LEAPS;
         ST_LEAPS:   state_in = ST_MONTHS;
         ST_MONTHS:  state_in = ST_DAYS;
         ST_DAYS:    state_in = ST_HOURS;
         ST_HOURS:   state_in = ST_MINUTES;
         ST_MINUTES: state_in = ST_ZONE;
         ST_ZONE:    state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mac_ctrl   = '0;
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_RECIP: begin
            mac_ctrl.en   = 1'b1;
            mac_ctrl.op_a = signed'(OP_A_W'(ym1));
            mac_ctrl.op_b = OP_B_W'(RECIP_100);
         end
         ST_YEARS: begin
            mac_ctrl.en     = 1'b1;
            mac_ctrl.op_a   = signed'(OP_A_W'(yoff));
            mac_ctrl.op_b   = OP_B_W'(DAYS_PER_YEAR);
            mac_ctrl.addend = signed'(OP_A_W'(ym1 >> 2));
         end
         ST_LEAPS: begin
            mac_ctrl.en     = 1'b1;
            mac_ctrl.keep   = 1'b1;
            mac_ctrl.addend = signed'(OP_A_W'(q100_ff >> 2)) - signed'(OP_A_W'(q100_ff))
                              - OP_A_W'(LEAPS_BEFORE_EPOCH);
         end
         ST_MONTHS: begin
            mac_ctrl.en     = 1'b1;
            mac_ctrl.keep   = 1'b1;
            mac_ctrl.addend = signed'(OP_A_W'(month_days)) + signed'(OP_A_W'(day_off));
         end
         ST_DAYS: begin
            mac_ctrl.en   = 1'b1;
            mac_ctrl.op_a = acc[OP_A_W-1:0];
            mac_ctrl.op_b = OP_B_W'(SECS_PER_DAY);
         end
         ST_HOURS: begin
            mac_ctrl.en   = 1'b1;
            mac_ctrl.keep = 1'b1;
            mac_ctrl.op_a = signed'(OP_A_W'(req_ff.hour));
            mac_ctrl.op_b = OP_B_W'(SECS_PER_HOUR);
         end
         ST_MINUTES: begin
            mac_ctrl.en     = 1'b1;
            mac_ctrl.keep   = 1'b1;
            mac_ctrl.op_a   = signed'(OP_A_W'(req_ff.minute));
            mac_ctrl.op_b   = OP_B_W'(SECS_PER_MIN);
            mac_ctrl.addend = signed'(OP_A_W'(req_ff.second));
         end
         ST_ZONE: begin
            mac_ctrl.en   = 1'b1;
            mac_ctrl.keep = 1'b1;
            mac_ctrl.op_a = zone_apply ? OP_A_W'(zone) : '0;
            mac_ctrl.op_b = -OP_B_W'(SECS_PER_MIN);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff    <= req_data;
         before_ff <= (req_data.year < EPOCH_YEAR);
      end
      if (state_ff == ST_YEARS) begin
         q100_ff <= acc[RECIP_SHIFT +: Q100_W];
      end
      if (state_ff == ST_LEAPS) begin
         leap_ff <= leap_in;
      end
   end

   udfte_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .acc   (acc)
   );

   assign rsp_data.epoch_seconds = before_ff ? '0 : acc[38:0];
   assign rsp_data.before_epoch  = before_ff;

endmodule

// ===== tb/tb_udf_timestamp_to_epoch_core.sv =====
// Self-checking testbench: directed and random timestamps vs. a calendar-arithmetic predictor.
`timescale 1ns / 100ps

module tb_udf_timestamp_to_epoch_core;
   import udfte_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   typedef struct {
      req_type stim;
      bit      known;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type      epoch_q[$];
   stim_row_type stim_rows[$];
   rsp_type      got_want;
   int           n_mismatch;
   int           idle_cycles;

   udf_timestamp_to_epoch_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit leap_year(longint y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
   endfunction

   function automatic longint leap_count(longint n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic longint month_length(int m, bit leap);
      if (m == 2) begin
         return leap ? 29 : 28;
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) begin
         return 30;
      end
      return 31;
   endfunction

   function automatic rsp_type ts_to_epoch(req_type r);
      rsp_type            res;
      longint             yr;
      longint             days;
      longint             secs;
      int                 mon;
      logic signed [11:0] zone;
      res = '0;
      if (r.year < EPOCH_YEAR) begin
         res.before_epoch = 1'b1;
         return res;
      end
      yr   = longint'(r.year);
      mon  = (r.month > LAST_MONTH) ? int'(LAST_MONTH) : int'(r.month);
      days = DAYS_PER_YEAR * (yr - 1970) + leap_count(yr - 1) - leap_count(1969);
      for (int m = 1; m < mon; m++) begin
         days += month_length(m, leap_year(yr));
      end
      if (r.day != 0) begin
         days += longint'(r.day) - 1;
      end
      secs = days * SECS_PER_DAY + longint'(r.hour) * SECS_PER_HOUR
           + longint'(r.minute) * SECS_PER_MIN + longint'(r.second);
      zone = r.type_and_zone[11:0];
      if (r.type_and_zone[ZONE_APPLY_BIT] && zone != ZONE_UNSPEC) begin
         secs -= longint'(zone) * SECS_PER_MIN;
      end
      res.epoch_seconds = secs[38:0];
      return res;
   endfunction

   function automatic req_type mk_req(int y, int mo, int d, int h, int mi, int s, int tz);
      req_type r;
      r.year          = y[13:0];
      r.month         = mo[3:0];
      r.day           = d[4:0];
      r.hour          = h[4:0];
      r.minute        = mi[5:0];
      r.second        = s[5:0];
      r.type_and_zone = tz[15:0];
      return r;
   endfunction

   function automatic rsp_type mk_rsp(longint secs, bit flag);
      rsp_type r;
      r.epoch_seconds = secs[38:0];
      r.before_epoch  = flag;
      return r;
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int      sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         r.year = 14'($urandom_range(0, 1969));
      end else if (sel < 20) begin
         r.year = 14'($urandom_range(0, 16383));
      end else if (sel < 70) begin
         r.year = 14'($urandom_range(1970, 2100));
      end else begin
         r.year = 14'($urandom_range(1970, 9999));
      end
      r.month  = 4'(($urandom_range(0, 9) != 0) ? $urandom_range(1, 12)
                                                : $urandom_range(0, 15));
      r.day    = 5'(($urandom_range(0, 9) != 0) ? $urandom_range(1, 31)
                                                : $urandom_range(0, 31));
      r.hour   = 5'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 23)
                                                : $urandom_range(0, 31));
      r.minute = 6'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 59)
                                                : $urandom_range(0, 63));
      r.second = 6'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 59)
                                                : $urandom_range(0, 63));
      sel = $urandom_range(0, 9);
      r.type_and_zone = 16'($urandom());
      if (sel < 4) begin
         r.type_and_zone[ZONE_APPLY_BIT] = 1'b1;
      end else if (sel == 4) begin
         r.type_and_zone[ZONE_APPLY_BIT] = 1'b1;
         r.type_and_zone[11:0] = ZONE_UNSPEC;
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         return 0;
      end
      if (sel < 92) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 60);
   endfunction

   task automatic note_mismatch(input string msg);
      n_mismatch++;
      if (n_mismatch <= 10) begin
         $display("%0t ERROR: %s", $realtime, msg);
      end
   endtask

   // one request: optional gap, then hold start until the block takes it
   task automatic issue(input req_type r, input bit known, input rsp_type want, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      epoch_q.push_back(known ? want : ts_to_epoch(r));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (epoch_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result %0d/%0d",
                                    rsp_data.epoch_seconds, rsp_data.before_epoch));
         end else begin
            got_want = epoch_q.pop_front();
            if (rsp_data.epoch_seconds !== got_want.epoch_seconds) begin
               note_mismatch($sformatf("epoch_seconds exp %0d got %0d",
                                       got_want.epoch_seconds, rsp_data.epoch_seconds));
            end
            if (rsp_data.before_epoch !== got_want.before_epoch) begin
               note_mismatch($sformatf("before_epoch exp %0b got %0b",
                                       got_want.before_epoch, rsp_data.before_epoch));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("udf_timestamp_to_epoch_core verification failed");
         $finish;
      end
   end

   initial begin
      bit no_idle;
      n_mismatch  = 0;
      idle_cycles = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;

      stim_rows.push_back('{mk_req(0, 1, 1, 0, 0, 0, 0), 1'b1, mk_rsp(0, 1'b1)});
      stim_rows.push_back('{mk_req(1969, 12, 31, 23, 59, 59, 'h1000), 1'b1, mk_rsp(0, 1'b1)});
      stim_rows.push_back('{mk_req(1970, 1, 1, 0, 0, 0, 0), 1'b1, mk_rsp(0, 1'b0)});
      stim_rows.push_back('{mk_req(1970, 1, 2, 0, 0, 0, 0), 1'b1, mk_rsp(86400, 1'b0)});
      stim_rows.push_back('{mk_req(1970, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 1'b0)});
      stim_rows.push_back('{mk_req(1970, 1, 1, 1, 1, 1, 0), 1'b1, mk_rsp(3661, 1'b0)});
      // unspecified zone code, zone bit clear with upper type bits set
      stim_rows.push_back('{mk_req(1970, 1, 1, 0, 0, 0, 'h1801), 1'b1, mk_rsp(0, 1'b0)});
      stim_rows.push_back('{mk_req(1970, 1, 1, 0, 0, 0, 'hEFFF), 1'b1, mk_rsp(0, 1'b0)});
      // zone extremes
      stim_rows.push_back('{mk_req(1970, 1, 1, 0, 0, 0, 'h1001), 1'b1, mk_rsp(-60, 1'b0)});
      stim_rows.push_back('{mk_req(1970, 1, 1, 0, 0, 0, 'h1800), 1'b1, mk_rsp(122880, 1'b0)});
      stim_rows.push_back('{mk_req(1970, 1, 1, 0, 0, 0, 'h17FF), 1'b1, mk_rsp(-122820, 1'b0)});
      stim_rows.push_back('{mk_req(1972, 2, 29, 12, 0, 0, 0), 1'b0, '0});
      stim_rows.push_back('{mk_req(1972, 3, 1, 0, 0, 0, 0), 1'b0, '0});
      stim_rows.push_back('{mk_req(2000, 3, 1, 0, 0, 0, 0), 1'b0, '0});
      stim_rows.push_back('{mk_req(2100, 3, 1, 0, 0, 0, 0), 1'b0, '0});
      stim_rows.push_back('{mk_req(1970, 13, 31, 0, 0, 0, 0), 1'b0, '0});
      stim_rows.push_back('{mk_req(1971, 15, 0, 0, 0, 0, 0), 1'b0, '0});
      stim_rows.push_back('{mk_req(1970, 12, 31, 31, 63, 63, 0), 1'b0, '0});
      stim_rows.push_back('{mk_req(2038, 1, 19, 3, 14, 8, 0), 1'b0, '0});
      stim_rows.push_back('{mk_req(2024, 7, 15, 12, 30, 45, 'h3F88), 1'b0, '0});
      stim_rows.push_back('{mk_req(9999, 12, 31, 23, 59, 59, 'h1800), 1'b0, '0});
      stim_rows.push_back('{mk_req(16383, 15, 31, 31, 63, 63, 'hFFFF), 1'b0, '0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         issue(stim_rows[i].stim, stim_rows[i].known, stim_rows[i].want, pick_gap());
      end

      no_idle = 1'b0;
      for (int n = 0; n < 1030; n++) begin
         if (n % 64 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         if (n % 250 == 125) begin
            // drain everything before the next request
            start <= 1'b0;
            @(posedge clock);
            while (epoch_q.size() != 0) @(posedge clock);
         end
         issue(rand_req(), 1'b0, '0, no_idle ? 0 : pick_gap());
      end

      start <= 1'b0;
      @(posedge clock);
      while (epoch_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (n_mismatch == 0) begin
         $display("udf_timestamp_to_epoch_core verification clean");
      end else begin
         $display("udf_timestamp_to_epoch_core verification failed");
      end
      $finish;
   end

endmodule
